### design/segx_pkg.sv
// Shared types and fixed constants for the segment intersection pipeline.
// No dependencies; imported by segment_intersection.
package segx_pkg;

  // Register stages in front of the quotient stages:
  // differences, products, determinants, hit test, partial products, dividend.
  localparam int FRONT_STAGES = 6;

  // Side information that travels with each request after the hit test.
  typedef struct packed {
    logic hit;    // both parameters within [0,1] and det nonzero
    logic neg_x;  // sign of tnum * d1x / det
    logic neg_y;  // sign of tnum * d1y / det
  } segx_flags_t;

endpackage

### design/segment_intersection.sv
// Throughput: one request per cycle; a stage holds its request only while every later
// stage is full and the output is stalled.
// The depth is set by the restoring divider, which resolves one quotient bit per stage.
// Reset (rst_n low, synchronous) empties every stage; payload registers are not cleared.
// Depends on segx_pkg for the flag type and the front stage count.
module segment_intersection #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_ray_start_x,
  input  logic signed [COORD_BITS-1:0] in_ray_start_y,
  input  logic signed [COORD_BITS-1:0] in_ray_end_x,
  input  logic signed [COORD_BITS-1:0] in_ray_end_y,
  input  logic signed [COORD_BITS-1:0] in_wall_start_x,
  input  logic signed [COORD_BITS-1:0] in_wall_start_y,
  input  logic signed [COORD_BITS-1:0] in_wall_end_x,
  input  logic signed [COORD_BITS-1:0] in_wall_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic signed [COORD_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS-1:0] out_cross_y
);
  import segx_pkg::*;

  localparam int N    = COORD_BITS;
  localparam int DW   = 2 * N + 3;          // signed det, tnum, unum
  localparam int MW   = 2 * N + 2;          // magnitudes of det and tnum
  localparam int HW   = (MW + 1) / 2;       // low slice of |tnum| per partial product
  localparam int LW   = MW - HW;            // high slice
  localparam int PW   = MW + N;             // dividend |tnum| * |d1|
  localparam int DIV0 = FRONT_STAGES;       // first quotient stage
  localparam int NS   = FRONT_STAGES + N + 1;
  localparam logic [NS-1:0] ALL_STAGES = '1;
  localparam logic signed [N+1:0] CLAMP_MAX = (N + 2)'((1 << (N - 1)) - 1);
  localparam logic signed [N+1:0] CLAMP_MIN = ~CLAMP_MAX;

  // ---------------------------------------------------------------
  // Stage occupancy and flow control
  // ---------------------------------------------------------------
  logic [NS-1:0] vld_r, vld_nxt, rdy;
  logic          out_free;

  assign out_free = !vld_r[NS-1] || out_ready;

  // A stage may load when the output drains or a bubble lies at or above it
  always_comb begin
    rdy = '0;
    for (int i = 0; i < NS; i++) begin
      rdy[i] = out_free || (|(~vld_r & (ALL_STAGES << i)));
    end
  end

  assign vld_nxt  = (rdy & {vld_r[NS-2:0], in_valid}) | (~rdy & vld_r);
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: direction and offset vectors
  // ---------------------------------------------------------------
  logic signed [N:0]   s1_d1x_r, s1_d1y_r, s1_d2x_r, s1_d2y_r, s1_wx_r, s1_wy_r;
  logic signed [N-1:0] s1_sx_r, s1_sy_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_d1x_r <= (N + 1)'(in_ray_end_x) - (N + 1)'(in_ray_start_x);
      s1_d1y_r <= (N + 1)'(in_ray_end_y) - (N + 1)'(in_ray_start_y);
      s1_d2x_r <= (N + 1)'(in_wall_end_x) - (N + 1)'(in_wall_start_x);
      s1_d2y_r <= (N + 1)'(in_wall_end_y) - (N + 1)'(in_wall_start_y);
      s1_wx_r  <= (N + 1)'(in_wall_start_x) - (N + 1)'(in_ray_start_x);
      s1_wy_r  <= (N + 1)'(in_wall_start_y) - (N + 1)'(in_ray_start_y);
      s1_sx_r  <= in_ray_start_x;
      s1_sy_r  <= in_ray_start_y;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: the six cross-product terms
  // ---------------------------------------------------------------
  logic signed [2*N+1:0] s2_da_r, s2_db_r, s2_ta_r, s2_tb_r, s2_ua_r, s2_ub_r;
  logic signed [N:0]     s2_d1x_r, s2_d1y_r;
  logic signed [N-1:0]   s2_sx_r, s2_sy_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_da_r  <= (2 * N + 2)'(s1_d1x_r) * (2 * N + 2)'(s1_d2y_r);
      s2_db_r  <= (2 * N + 2)'(s1_d1y_r) * (2 * N + 2)'(s1_d2x_r);
      s2_ta_r  <= (2 * N + 2)'(s1_wx_r) * (2 * N + 2)'(s1_d2y_r);
      s2_tb_r  <= (2 * N + 2)'(s1_wy_r) * (2 * N + 2)'(s1_d2x_r);
      s2_ua_r  <= (2 * N + 2)'(s1_wx_r) * (2 * N + 2)'(s1_d1y_r);
      s2_ub_r  <= (2 * N + 2)'(s1_wy_r) * (2 * N + 2)'(s1_d1x_r);
      s2_d1x_r <= s1_d1x_r;
      s2_d1y_r <= s1_d1y_r;
      s2_sx_r  <= s1_sx_r;
      s2_sy_r  <= s1_sy_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: determinant and parameter numerators
  // ---------------------------------------------------------------
  logic signed [DW-1:0] s3_det_r, s3_tnum_r, s3_unum_r;
  logic signed [N:0]    s3_d1x_r, s3_d1y_r;
  logic signed [N-1:0]  s3_sx_r, s3_sy_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_det_r  <= DW'(s2_da_r) - DW'(s2_db_r);
      s3_tnum_r <= DW'(s2_ta_r) - DW'(s2_tb_r);
      s3_unum_r <= DW'(s2_ua_r) - DW'(s2_ub_r);
      s3_d1x_r  <= s2_d1x_r;
      s3_d1y_r  <= s2_d1y_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: range test on t and u, magnitudes and result signs
  // ---------------------------------------------------------------
  logic        det_pos, det_neg, t_in, u_in;
  segx_flags_t s4_flags_nxt;

  assign det_pos = !s3_det_r[DW-1] && (s3_det_r != '0);
  assign det_neg = s3_det_r[DW-1];
  assign t_in = det_pos ? (!s3_tnum_r[DW-1] && (s3_tnum_r <= s3_det_r))
                        : (det_neg && (s3_tnum_r <= 0) && (s3_tnum_r >= s3_det_r));
  assign u_in = det_pos ? (!s3_unum_r[DW-1] && (s3_unum_r <= s3_det_r))
                        : (det_neg && (s3_unum_r <= 0) && (s3_unum_r >= s3_det_r));

  always_comb begin
    s4_flags_nxt.hit   = t_in && u_in;
    s4_flags_nxt.neg_x = s3_tnum_r[DW-1] ^ s3_d1x_r[N] ^ s3_det_r[DW-1];
    s4_flags_nxt.neg_y = s3_tnum_r[DW-1] ^ s3_d1y_r[N] ^ s3_det_r[DW-1];
  end

  logic [MW-1:0]       s4_dmag_r, s4_tmag_r;
  logic [N-1:0]        s4_dmx_r, s4_dmy_r;
  logic signed [N-1:0] s4_sx_r, s4_sy_r;
  segx_flags_t         s4_flags_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_dmag_r  <= MW'(s3_det_r[DW-1] ? -s3_det_r : s3_det_r);
      s4_tmag_r  <= MW'(s3_tnum_r[DW-1] ? -s3_tnum_r : s3_tnum_r);
      s4_dmx_r   <= N'(s3_d1x_r[N] ? -s3_d1x_r : s3_d1x_r);
      s4_dmy_r   <= N'(s3_d1y_r[N] ? -s3_d1y_r : s3_d1y_r);
      s4_sx_r    <= s3_sx_r;
      s4_sy_r    <= s3_sy_r;
      s4_flags_r <= s4_flags_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: |tnum| * |d1| as two partial products per axis
  // ---------------------------------------------------------------
  logic [HW+N-1:0]     s5_lox_r, s5_loy_r;
  logic [LW+N-1:0]     s5_hix_r, s5_hiy_r;
  logic [MW-1:0]       s5_dmag_r;
  logic signed [N-1:0] s5_sx_r, s5_sy_r;
  segx_flags_t         s5_flags_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_lox_r   <= (HW + N)'(s4_tmag_r[HW-1:0]) * (HW + N)'(s4_dmx_r);
      s5_loy_r   <= (HW + N)'(s4_tmag_r[HW-1:0]) * (HW + N)'(s4_dmy_r);
      s5_hix_r   <= (LW + N)'(s4_tmag_r[MW-1:HW]) * (LW + N)'(s4_dmx_r);
      s5_hiy_r   <= (LW + N)'(s4_tmag_r[MW-1:HW]) * (LW + N)'(s4_dmy_r);
      s5_dmag_r  <= s4_dmag_r;
      s5_sx_r    <= s4_sx_r;
      s5_sy_r    <= s4_sy_r;
      s5_flags_r <= s4_flags_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 6: combine partial products into the dividends
  // ---------------------------------------------------------------
  logic [PW-1:0]       s6_px_r, s6_py_r;
  logic [MW-1:0]       s6_dmag_r;
  logic signed [N-1:0] s6_sx_r, s6_sy_r;
  segx_flags_t         s6_flags_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_px_r    <= (PW'(s5_hix_r) << HW) + PW'(s5_lox_r);
      s6_py_r    <= (PW'(s5_hiy_r) << HW) + PW'(s5_loy_r);
      s6_dmag_r  <= s5_dmag_r;
      s6_sx_r    <= s5_sx_r;
      s6_sy_r    <= s5_sy_r;
      s6_flags_r <= s5_flags_r;
    end
  end

  // ---------------------------------------------------------------
  // Quotient stages: restoring division, one bit per stage, MSB first.
  // On a hit the quotient is at most |d1|, so N bits suffice and the
  // upper dividend bits start below the divisor.
  // ---------------------------------------------------------------
  logic [MW-1:0]       dv_rx_r   [N];
  logic [MW-1:0]       dv_ry_r   [N];
  logic [N-1:0]        dv_qx_r   [N];
  logic [N-1:0]        dv_qy_r   [N];
  logic [N-1:0]        dv_plx_r  [N];
  logic [N-1:0]        dv_ply_r  [N];
  logic [MW-1:0]       dv_dmag_r [N];
  logic signed [N-1:0] dv_sx_r   [N];
  logic signed [N-1:0] dv_sy_r   [N];
  segx_flags_t         dv_flags_r[N];

  for (genvar k = 0; k < N; k++) begin : g_div
    logic [MW-1:0]       rx_in, ry_in, dmag_in;
    logic [N-1:0]        qx_in, qy_in, plx_in, ply_in;
    logic signed [N-1:0] sx_in, sy_in;
    segx_flags_t         flags_in;
    logic [MW:0]         tx, ty, dx, dy;
    logic                gex, gey;

    // Take the dividend from stage 6 or from the previous quotient stage
    if (k == 0) begin : g_first
      assign rx_in    = s6_px_r[PW-1:N];
      assign ry_in    = s6_py_r[PW-1:N];
      assign qx_in    = '0;
      assign qy_in    = '0;
      assign plx_in   = s6_px_r[N-1:0];
      assign ply_in   = s6_py_r[N-1:0];
      assign dmag_in  = s6_dmag_r;
      assign sx_in    = s6_sx_r;
      assign sy_in    = s6_sy_r;
      assign flags_in = s6_flags_r;
    end else begin : g_next
      assign rx_in    = dv_rx_r[k-1];
      assign ry_in    = dv_ry_r[k-1];
      assign qx_in    = dv_qx_r[k-1];
      assign qy_in    = dv_qy_r[k-1];
      assign plx_in   = dv_plx_r[k-1];
      assign ply_in   = dv_ply_r[k-1];
      assign dmag_in  = dv_dmag_r[k-1];
      assign sx_in    = dv_sx_r[k-1];
      assign sy_in    = dv_sy_r[k-1];
      assign flags_in = dv_flags_r[k-1];
    end

    // Shift in the next dividend bit and trial-subtract the divisor
    assign tx  = {rx_in, plx_in[N-1-k]};
    assign ty  = {ry_in, ply_in[N-1-k]};
    assign dx  = tx - {1'b0, dmag_in};
    assign dy  = ty - {1'b0, dmag_in};
    assign gex = tx >= {1'b0, dmag_in};
    assign gey = ty >= {1'b0, dmag_in};

    always_ff @(posedge clk) begin
      if (rdy[DIV0+k]) begin
        dv_rx_r[k]    <= gex ? dx[MW-1:0] : tx[MW-1:0];
        dv_ry_r[k]    <= gey ? dy[MW-1:0] : ty[MW-1:0];
        dv_qx_r[k]    <= {qx_in[N-2:0], gex};
        dv_qy_r[k]    <= {qy_in[N-2:0], gey};
        dv_plx_r[k]   <= plx_in;
        dv_ply_r[k]   <= ply_in;
        dv_dmag_r[k]  <= dmag_in;
        dv_sx_r[k]    <= sx_in;
        dv_sy_r[k]    <= sy_in;
        dv_flags_r[k] <= flags_in;
      end
    end
  end

  // ---------------------------------------------------------------
  // Output stage: apply sign, add ray start, clamp, zero on a miss
  // ---------------------------------------------------------------
  segx_flags_t         fin_flags;
  logic signed [N:0]   offx, offy;
  logic signed [N+1:0] sumx, sumy;
  logic signed [N-1:0] cx_nxt, cy_nxt;

  assign fin_flags = dv_flags_r[N-1];
  assign offx = fin_flags.neg_x ? -$signed({1'b0, dv_qx_r[N-1]}) : $signed({1'b0, dv_qx_r[N-1]});
  assign offy = fin_flags.neg_y ? -$signed({1'b0, dv_qy_r[N-1]}) : $signed({1'b0, dv_qy_r[N-1]});
  assign sumx = (N + 2)'(dv_sx_r[N-1]) + (N + 2)'(offx);
  assign sumy = (N + 2)'(dv_sy_r[N-1]) + (N + 2)'(offy);

  always_comb begin
    if (!fin_flags.hit) begin
      cx_nxt = '0;
    end else if (sumx > CLAMP_MAX) begin
      cx_nxt = CLAMP_MAX[N-1:0];
    end else if (sumx < CLAMP_MIN) begin
      cx_nxt = CLAMP_MIN[N-1:0];
    end else begin
      cx_nxt = sumx[N-1:0];
    end
    if (!fin_flags.hit) begin
      cy_nxt = '0;
    end else if (sumy > CLAMP_MAX) begin
      cy_nxt = CLAMP_MAX[N-1:0];
    end else if (sumy < CLAMP_MIN) begin
      cy_nxt = CLAMP_MIN[N-1:0];
    end else begin
      cy_nxt = sumy[N-1:0];
    end
  end

  logic                out_hit_r;
  logic signed [N-1:0] out_cross_x_r, out_cross_y_r;

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      out_hit_r     <= fin_flags.hit;
      out_cross_x_r <= cx_nxt;
      out_cross_y_r <= cy_nxt;
    end
  end

  assign out_valid   = vld_r[NS-1];
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_cross_x_r;
  assign out_cross_y = out_cross_y_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  // Input side may only block when every stage holds a request
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (vld_r == ALL_STAGES))
    else $error("input stalled with a free stage");

  // An accepted request always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted request not captured");

  // A miss carries a zero crossing point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_cross_x == '0 && out_cross_y == '0))
    else $error("miss with nonzero crossing");

endmodule

### sim/segment_intersection_checker.sv
// Result checker for segment_intersection: watches both channels, predicts each
// crossing from the accepted request and compares it with the block's result.
// No dependencies beyond the signals it is connected to.
`timescale 1ns / 1ps

module segment_intersection_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_ray_start_x,
  input  logic signed [COORD_BITS-1:0] in_ray_start_y,
  input  logic signed [COORD_BITS-1:0] in_ray_end_x,
  input  logic signed [COORD_BITS-1:0] in_ray_end_y,
  input  logic signed [COORD_BITS-1:0] in_wall_start_x,
  input  logic signed [COORD_BITS-1:0] in_wall_start_y,
  input  logic signed [COORD_BITS-1:0] in_wall_end_x,
  input  logic signed [COORD_BITS-1:0] in_wall_end_y,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_hit,
  input  logic signed [COORD_BITS-1:0] out_cross_x,
  input  logic signed [COORD_BITS-1:0] out_cross_y,
  output int                           fault_count,
  output int                           awaiting
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
  } crossing_t;

  crossing_t pending_crossings[$];
  int        faults = 0;
  int        reported = 0;
  int        result_index = 0;

  // True when num/den lies in [0,1], endpoints included, without dividing
  function automatic bit within_unit(input longint num, input longint den);
    if (den > 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  // Exact trunc(num * dir / den) on magnitudes, sign applied afterwards
  function automatic longint scaled_offset(input longint num, input longint dir,
                                           input longint den);
    logic [127:0] prod;
    logic [127:0] quot;
    logic [63:0]  mag_num;
    logic [63:0]  mag_dir;
    logic [63:0]  mag_den;
    bit           neg;
    longint       q;
    if (num == 0 || dir == 0) return 0;
    neg     = ((num < 0) != (dir < 0)) != (den < 0);
    mag_num = (num < 0) ? -num : num;
    mag_dir = (dir < 0) ? -dir : dir;
    mag_den = (den < 0) ? -den : den;
    prod    = {64'd0, mag_num} * {64'd0, mag_dir};
    quot    = prod / {64'd0, mag_den};
    if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
    q = longint'(quot[63:0]);
    return neg ? -q : q;
  endfunction

  // Saturate to the signed coordinate range
  function automatic coord_t saturate(input longint v);
    longint top_v;
    longint bot_v;
    longint w;
    top_v = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    bot_v = -top_v - 1;
    w = v;
    if (w > top_v) w = top_v;
    if (w < bot_v) w = bot_v;
    return w[COORD_BITS-1:0];
  endfunction

  function automatic crossing_t predict_crossing(
    input coord_t rsx, input coord_t rsy, input coord_t rex, input coord_t rey,
    input coord_t wsx, input coord_t wsy, input coord_t wex, input coord_t wey);
    longint    sx, sy, d1x, d1y, d2x, d2y, wx, wy;
    longint    det, tnum, unum;
    crossing_t r;
    sx   = longint'(rsx);
    sy   = longint'(rsy);
    d1x  = longint'(rex) - sx;
    d1y  = longint'(rey) - sy;
    d2x  = longint'(wex) - longint'(wsx);
    d2y  = longint'(wey) - longint'(wsy);
    wx   = longint'(wsx) - sx;
    wy   = longint'(wsy) - sy;
    det  = d1x * d2y - d1y * d2x;
    tnum = wx * d2y - wy * d2x;
    unum = wx * d1y - wy * d1x;
    r = '0;
    // Parallel, degenerate or out-of-range parameters: no hit, zero point
    if (det == 0 || !within_unit(tnum, det) || !within_unit(unum, det)) return r;
    r.hit     = 1'b1;
    r.cross_x = saturate(sx + scaled_offset(tnum, d1x, det));
    r.cross_y = saturate(sy + scaled_offset(tnum, d1y, det));
    return r;
  endfunction

  // Record each accepted request, compare each accepted result with the oldest
  always @(posedge clk) begin : watch_channels
    crossing_t want;
    crossing_t fresh;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        fresh = predict_crossing(
          in_ray_start_x, in_ray_start_y, in_ray_end_x, in_ray_end_y,
          in_wall_start_x, in_wall_start_y, in_wall_end_x, in_wall_end_y);
        pending_crossings.insert(pending_crossings.size(), fresh);
      end
      if (out_valid && out_ready) begin
        if (pending_crossings.size() == 0) begin
          faults++;
          if (reported < 10) begin
            reported++;
            $display("result %0d: unexpected, got hit=%0b x=%0d y=%0d", result_index,
                     out_hit, out_cross_x, out_cross_y);
          end
        end else begin
          want = pending_crossings.pop_front();
          if (out_hit !== want.hit || out_cross_x !== want.cross_x ||
              out_cross_y !== want.cross_y) begin
            faults++;
            if (reported < 10) begin
              reported++;
              $display("result %0d: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                       result_index, want.hit, $signed(want.cross_x), $signed(want.cross_y),
                       out_hit, out_cross_x, out_cross_y);
            end
          end
        end
        result_index++;
      end
    end
    fault_count <= faults;
    awaiting    <= pending_crossings.size();
  end

endmodule

### sim/segment_intersection_tb.sv
// Top of the segment_intersection testbench: clock, reset, request stimulus and
// result back-pressure. Depends on segx_pkg, segment_intersection and the checker.
`timescale 1ns / 1ps

module segment_intersection_tb;

  localparam int COORD_BITS = 16;
  localparam int CMAX       = 2 ** (COORD_BITS - 1) - 1;
  localparam int CMIN       = -CMAX - 1;
  localparam int HALF       = CMAX / 2;
  localparam int QUART      = CMAX / 4;
  localparam int DRAIN      = 2 * (COORD_BITS + segx_pkg::FRONT_STAGES + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLDOFF_CYCLES = 300;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t rsx, rsy, rex, rey;
    coord_t wsx, wsy, wex, wey;
  } seg_pair_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_ray_start_x = '0;
  coord_t in_ray_start_y = '0;
  coord_t in_ray_end_x = '0;
  coord_t in_ray_end_y = '0;
  coord_t in_wall_start_x = '0;
  coord_t in_wall_start_y = '0;
  coord_t in_wall_end_x = '0;
  coord_t in_wall_end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_hit;
  coord_t out_cross_x;
  coord_t out_cross_y;
  int     fault_count;
  int     awaiting;

  int   idle_pct = 0;
  int   stall_pct = 0;
  int   holdoff_left = 0;
  logic holdoff_req = 1'b0;
  logic holdoff_done = 1'b0;
  int   cycles = 0;

  segment_intersection #(.COORD_BITS(COORD_BITS)) dut (.*);

  segment_intersection_checker #(.COORD_BITS(COORD_BITS)) result_checker (.*);

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: one long hold-off when asked, otherwise random stalls
  always @(posedge clk) begin
    if (holdoff_req && !holdoff_done) begin
      out_ready    <= 1'b0;
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES - 1;
    end else if (holdoff_left > 0) begin
      out_ready    <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  function automatic coord_t to_coord(input int v);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic int rand_span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic seg_pair_t pair_of(input int a, input int b, input int c, input int d,
                                        input int e, input int f, input int g, input int h);
    seg_pair_t p;
    p.rsx = to_coord(a); p.rsy = to_coord(b); p.rex = to_coord(c); p.rey = to_coord(d);
    p.wsx = to_coord(e); p.wsy = to_coord(f); p.wex = to_coord(g); p.wey = to_coord(h);
    return p;
  endfunction

  function automatic int corner_value();
    case ($urandom_range(5))
      0: return CMIN;
      1: return CMAX;
      2: return CMIN + 1;
      3: return CMAX - 1;
      4: return -1;
      default: return 0;
    endcase
  endfunction

  // A mix of segment pairs built to cross, parallel, tiny, corner and raw noise
  function automatic seg_pair_t random_pair();
    int sel, rsx, rsy, rex, rey, px, py, vx, vy, k, j, dx, dy, wsx, wsy, m, n;
    sel = $urandom_range(99);
    if (sel < 30) begin
      return pair_of($urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom());
    end else if (sel < 45) begin
      return pair_of(rand_span(-8, 8), rand_span(-8, 8), rand_span(-8, 8), rand_span(-8, 8),
                     rand_span(-8, 8), rand_span(-8, 8), rand_span(-8, 8), rand_span(-8, 8));
    end else if (sel < 75) begin
      // Pick a point on the ray, then run the wall through it
      rsx = rand_span(-HALF, HALF);
      rsy = rand_span(-HALF, HALF);
      rex = rand_span(-HALF, HALF);
      rey = rand_span(-HALF, HALF);
      k   = $urandom_range(16);
      px  = rsx + ((rex - rsx) * k) / 16;
      py  = rsy + ((rey - rsy) * k) / 16;
      vx  = rand_span(-QUART, QUART);
      vy  = rand_span(-QUART, QUART);
      j   = $urandom_range(4);
      return pair_of(rsx, rsy, rex, rey, px + vx, py + vy,
                     px - (vx * j) / 4, py - (vy * j) / 4);
    end else if (sel < 90) begin
      // Wall direction a multiple of the ray direction, sometimes on the same line
      dx  = rand_span(-CMAX / 16, CMAX / 16);
      dy  = rand_span(-CMAX / 16, CMAX / 16);
      rsx = rand_span(-HALF, HALF);
      rsy = rand_span(-HALF, HALF);
      m   = rand_span(-4, 4);
      if ($urandom_range(2) == 0) begin
        n   = rand_span(-3, 3);
        wsx = rsx + dx * n;
        wsy = rsy + dy * n;
      end else begin
        wsx = rand_span(-HALF, HALF);
        wsy = rand_span(-HALF, HALF);
      end
      return pair_of(rsx, rsy, rsx + dx, rsy + dy, wsx, wsy, wsx + dx * m, wsy + dy * m);
    end
    return pair_of(corner_value(), corner_value(), corner_value(), corner_value(),
                   corner_value(), corner_value(), corner_value(), corner_value());
  endfunction

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_pair(input seg_pair_t p);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid        <= 1'b1;
    in_ray_start_x  <= p.rsx;
    in_ray_start_y  <= p.rsy;
    in_ray_end_x    <= p.rex;
    in_ray_end_y    <= p.rey;
    in_wall_start_x <= p.wsx;
    in_wall_start_y <= p.wsy;
    in_wall_end_x   <= p.wex;
    in_wall_end_y   <= p.wey;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall);
    idle_pct = idle;
    stall_pct <= stall;
    repeat (count) send_pair(random_pair());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, endpoint touches, parallel and degenerate pairs
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_pair(pair_of(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_pair(pair_of(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
    send_pair(pair_of(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN));
    send_pair(pair_of(CMAX, CMAX, CMIN, CMIN, CMIN, 0, CMAX, 0));
    send_pair(pair_of(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX));
    send_pair(pair_of(0, 0, 160, 160, 0, 160, 160, 0));
    send_pair(pair_of(0, 0, 100, 0, 0, -50, 0, 50));
    send_pair(pair_of(0, 0, 100, 0, 100, -50, 100, 50));
    send_pair(pair_of(0, 0, 100, 0, 50, 0, 50, 50));
    send_pair(pair_of(0, 0, 100, 0, 50, 50, 50, 0));
    send_pair(pair_of(0, 0, 100, 0, 101, -50, 101, 50));
    send_pair(pair_of(0, 0, 100, 0, 50, 1, 50, 50));
    send_pair(pair_of(0, 0, 100, 0, 50, -50, 50, 50));
    send_pair(pair_of(0, 0, 100, 0, 50, 50, 50, -50));
    send_pair(pair_of(0, 0, 100, 0, 0, 10, 100, 10));
    send_pair(pair_of(0, 0, 100, 0, 50, 0, 150, 0));
    send_pair(pair_of(5, 5, 5, 5, 0, 0, 10, 10));
    send_pair(pair_of(0, 0, -100, -33, -50, 10, -30, -40));
    send_pair(pair_of(0, 0, 100, 100, 100, 100, 200, 0));
    send_pair(pair_of(-1, -1, 1, 1, -1, 1, 1, -1));

    // Random phases under different idle and stall rates
    run_phase(150, 0, 0);
    run_phase(150, 79, 0);
    run_phase(150, 0, 79);
    run_phase(150, 14, 14);

    // Hold the receiver off while requests keep coming, to fill the pipeline
    idle_pct = 0;
    stall_pct <= 0;
    holdoff_req <= 1'b1;
    repeat (60) send_pair(random_pair());
    in_valid <= 1'b0;

    // Drain, then allow for any late result
    do @(posedge clk); while (awaiting != 0);
    repeat (DRAIN) @(posedge clk);

    if (fault_count == 0 && awaiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
